FILE: design/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants for the bounding box accumulator
// Register map, input mode codes, the control word that travels through the
// item queue and the configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int QUEUE_DEPTH_DEF = 8;

    localparam int COEF_WIDTH      = 16;
    localparam int ROW_WIDTH       = 48;
    localparam int SHIFT_WIDTH     = 24;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 48;
    localparam int ROUND_SHIFT     = 14;

    // Identity matrix, 1.0 in Q2.14 on the diagonal
    localparam logic [ROW_WIDTH-1:0] ROW_X_RST = 48'h0000_0000_4000;
    localparam logic [ROW_WIDTH-1:0] ROW_Y_RST = 48'h0000_4000_0000;
    localparam logic [ROW_WIDTH-1:0] ROW_Z_RST = 48'h4000_0000_0000;

    typedef enum logic [1:0] {
        MODE_POINT = 2'd0,
        MODE_MERGE = 2'd1,
        MODE_QUERY = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_XFORM_EN = 3'd0,
        CFG_ROW_X    = 3'd1,
        CFG_ROW_Y    = 3'd2,
        CFG_ROW_Z    = 3'd3,
        CFG_SHIFT_X  = 3'd4,
        CFG_SHIFT_Y  = 3'd5,
        CFG_SHIFT_Z  = 3'd6
    } t_cfg_idx;

    typedef enum logic {
        OP_WIDEN = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef struct packed {
        t_op  op;
        logic first;
        logic last;
    } t_ctl;

    localparam int CTL_WIDTH = $bits(t_ctl);

    typedef struct packed {
        logic                   xform_en;
        logic [ROW_WIDTH-1:0]   row_x;
        logic [ROW_WIDTH-1:0]   row_y;
        logic [ROW_WIDTH-1:0]   row_z;
        logic [SHIFT_WIDTH-1:0] shift_x;
        logic [SHIFT_WIDTH-1:0] shift_y;
        logic [SHIFT_WIDTH-1:0] shift_z;
    } t_cfg;

endpackage

`default_nettype wire

FILE: design/bba_fifo.sv
// ----------------------------------------------------------------------------
// bba_fifo: short item queue between front and back
// Register-based ring buffer with a fill level; head is shown combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [WIDTH-1:0]           i_push_data,
    input  wire logic                       i_pop,
    output logic                            o_valid,
    output logic [WIDTH-1:0]                o_data,
    output logic [$clog2(DEPTH+1)-1:0]      o_level,
    output logic                            o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [LW-1:0]    r_level;
    logic             do_push, do_pop;

    assign o_valid = (r_level != '0);
    assign o_full  = (r_level == LW'(DEPTH));
    assign o_level = r_level;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_level <= r_level + LW'(1);
            end else if (!do_push && do_pop) begin
                r_level <= r_level - LW'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/bba_front.sv
// ----------------------------------------------------------------------------
// bba_front: item intake, classification and point transform
// Accepts beats against queue credit, drops unused modes, and runs points
// through three affine stages (input, multiply, sum), then round/saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_front
    import bba_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [1:0]                        i_mode,
    input  wire logic                              i_first,
    input  wire logic                              i_last,
    input  wire logic signed [COORD_WIDTH-1:0]     i_ax,
    input  wire logic signed [COORD_WIDTH-1:0]     i_ay,
    input  wire logic signed [COORD_WIDTH-1:0]     i_az,
    input  wire logic signed [COORD_WIDTH-1:0]     i_bx,
    input  wire logic signed [COORD_WIDTH-1:0]     i_by,
    input  wire logic signed [COORD_WIDTH-1:0]     i_bz,
    input  wire t_cfg                              i_cfg,
    input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]  i_q_level,
    output logic                                   o_push,
    output logic [CTL_WIDTH+6*COORD_WIDTH-1:0]     o_push_data,
    output logic [1:0]                             o_inflight
);

    localparam int CW = COORD_WIDTH;
    localparam int LW = $clog2(QUEUE_DEPTH + 1);
    localparam int PW = COEF_WIDTH + CW;
    localparam int SW = PW + 2;

    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [SW:0]   TMAX = (SW+1)'(CMAX);
    localparam logic signed [SW:0]   TMIN = (SW+1)'(CMIN);
    localparam logic signed [SW-1:0] RND  = SW'(2 ** (ROUND_SHIFT - 1));

    logic signed [CW-1:0] in_a [3];
    logic signed [CW-1:0] n_b  [3];
    t_ctl                 n_ctl;
    logic                 n_keep, n_xf;
    logic                 accept;
    logic [LW:0]          claims;

    logic [ROW_WIDTH-1:0]   rows   [3];
    logic [SHIFT_WIDTH-1:0] shifts [3];

    // stage 1: registered input
    logic                 r_v1, r_xf1;
    t_ctl                 r_ctl1;
    logic signed [CW-1:0] r_a1 [3];
    logic signed [CW-1:0] r_b1 [3];
    // stage 2: products
    logic                 r_v2, r_xf2;
    t_ctl                 r_ctl2;
    logic signed [CW-1:0] r_a2 [3];
    logic signed [CW-1:0] r_b2 [3];
    logic signed [PW-1:0] r_prod [3][3];
    // stage 3: row sums
    logic                 r_v3, r_xf3;
    t_ctl                 r_ctl3;
    logic signed [CW-1:0] r_a3 [3];
    logic signed [CW-1:0] r_b3 [3];
    logic signed [SW-1:0] r_sum [3];

    logic signed [SW-1:0] quo    [3];
    logic [31:0]          sh_ext [3];
    logic signed [CW-1:0] sh_val [3];
    logic signed [SW:0]   tsum   [3];
    logic signed [CW-1:0] sat    [3];
    logic signed [CW-1:0] out_a  [3];
    logic signed [CW-1:0] out_b  [3];

    assign in_a = '{i_ax, i_ay, i_az};
    assign rows   = '{i_cfg.row_x, i_cfg.row_y, i_cfg.row_z};
    assign shifts = '{i_cfg.shift_x, i_cfg.shift_y, i_cfg.shift_z};

    // Credit: every item in the pipe already owns a queue slot
    assign o_inflight = 2'(r_v1) + 2'(r_v2) + 2'(r_v3);
    assign claims     = (LW+1)'(i_q_level) + (LW+1)'(o_inflight);
    assign o_in_stall = (claims >= (LW+1)'(QUEUE_DEPTH));
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_keep    = 1'b1;
        n_xf      = 1'b0;
        n_ctl.op    = OP_WIDEN;
        n_ctl.first = i_first;
        n_ctl.last  = i_last;
        n_b       = '{i_bx, i_by, i_bz};
        case (t_mode'(i_mode))
            MODE_POINT: begin
                n_xf = i_cfg.xform_en;
                n_b  = in_a;
            end
            MODE_MERGE: begin
                n_keep = 1'b1;
            end
            MODE_QUERY: begin
                n_ctl.op = OP_QUERY;
            end
            default: begin
                n_keep = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= accept && n_keep;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xf1  <= n_xf;
        r_ctl1 <= n_ctl;
        r_a1   <= in_a;
        r_b1   <= n_b;

        r_xf2  <= r_xf1;
        r_ctl2 <= r_ctl1;
        r_a2   <= r_a1;
        r_b2   <= r_b1;
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                r_prod[r][k] <= $signed(rows[r][COEF_WIDTH*k +: COEF_WIDTH]) * r_a1[k];
            end
        end

        r_xf3  <= r_xf2;
        r_ctl3 <= r_ctl2;
        r_a3   <= r_a2;
        r_b3   <= r_b2;
        for (int r = 0; r < 3; r++) begin
            r_sum[r] <= SW'(r_prod[r][0]) + SW'(r_prod[r][1]) + SW'(r_prod[r][2]) + RND;
        end
    end

    // Round half up from Q2.14, add translation, clamp to the coordinate range
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            quo[r]    = r_sum[r] >>> ROUND_SHIFT;
            sh_ext[r] = 32'(shifts[r]);
            sh_val[r] = $signed(sh_ext[r][CW-1:0]);
            tsum[r]   = (SW+1)'(quo[r]) + (SW+1)'(sh_val[r]);
            if (tsum[r] > TMAX) begin
                sat[r] = CMAX;
            end else if (tsum[r] < TMIN) begin
                sat[r] = CMIN;
            end else begin
                sat[r] = tsum[r][CW-1:0];
            end
            out_a[r] = r_xf3 ? sat[r] : r_a3[r];
            out_b[r] = r_xf3 ? sat[r] : r_b3[r];
        end
    end

    assign o_push      = r_v3;
    assign o_push_data = {r_ctl3, out_a[0], out_a[1], out_a[2], out_b[0], out_b[1], out_b[2]};

endmodule

`default_nettype wire

FILE: design/bba_back.sv
// ----------------------------------------------------------------------------
// bba_back: box update, overlap test and result register
// Pops queued items, widens or tests the stored box, and holds the result beat
// in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_back
    import bba_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_q_valid,
    input  wire logic [CTL_WIDTH+6*COORD_WIDTH-1:0]  i_q_data,
    output logic                                     o_pop,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic signed [COORD_WIDTH-1:0]            o_low_x,
    output logic signed [COORD_WIDTH-1:0]            o_low_y,
    output logic signed [COORD_WIDTH-1:0]            o_low_z,
    output logic signed [COORD_WIDTH-1:0]            o_high_x,
    output logic signed [COORD_WIDTH-1:0]            o_high_y,
    output logic signed [COORD_WIDTH-1:0]            o_high_z,
    output logic                                     o_overlap
);

    localparam int CW = COORD_WIDTH;
    localparam int IW = CTL_WIDTH + 6 * CW;

    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    t_ctl                 ctl;
    logic signed [CW-1:0] a [3];
    logic signed [CW-1:0] b [3];
    logic signed [CW-1:0] base_low  [3];
    logic signed [CW-1:0] base_high [3];
    logic signed [CW-1:0] n_low  [3];
    logic signed [CW-1:0] n_high [3];
    logic                 hit, emit, out_free;

    logic signed [CW-1:0] r_low  [3];
    logic signed [CW-1:0] r_high [3];
    logic                 r_out_valid, r_overlap;
    logic signed [CW-1:0] r_out_low  [3];
    logic signed [CW-1:0] r_out_high [3];

    assign ctl = t_ctl'(i_q_data[IW-1 -: CTL_WIDTH]);

    always_comb begin
        hit = 1'b1;
        for (int k = 0; k < 3; k++) begin
            a[k]         = i_q_data[(5-k)*CW +: CW];
            b[k]         = i_q_data[(2-k)*CW +: CW];
            base_low[k]  = ctl.first ? CMAX : r_low[k];
            base_high[k] = ctl.first ? CMIN : r_high[k];
            n_low[k]     = (a[k] < base_low[k])  ? a[k] : base_low[k];
            n_high[k]    = (b[k] > base_high[k]) ? b[k] : base_high[k];
            hit          = hit && (r_low[k] <= b[k]) && (r_high[k] >= a[k]);
        end
    end

    assign emit     = (ctl.op == OP_QUERY) || ctl.last;
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = i_q_valid && (!emit || out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_low[k]  <= CMAX;
                r_high[k] <= CMIN;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && ctl.op == OP_WIDEN) begin
                r_low  <= n_low;
                r_high <= n_high;
            end
            if (o_pop && emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            if (ctl.op == OP_QUERY) begin
                r_out_low  <= r_low;
                r_out_high <= r_high;
                r_overlap  <= hit;
            end else begin
                r_out_low  <= n_low;
                r_out_high <= n_high;
                r_overlap  <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_low_x     = r_out_low[0];
    assign o_low_y     = r_out_low[1];
    assign o_low_z     = r_out_low[2];
    assign o_high_x    = r_out_high[0];
    assign o_high_y    = r_out_high[1];
    assign o_high_z    = r_out_high[2];
    assign o_overlap   = r_overlap;

endmodule

`default_nettype wire

FILE: design/bounding_box_accumulator.sv
// Path: an accepted beat that causes a result passes the input register, multiply
//   and row sum stages, the queue and the box update into the result register.
// Throughput: one beat per cycle while o_in_stall is low; the min/max update of the
//   stored box keeps pace and the transform is fully pipelined ahead of the queue.
// Reset: synchronous, active low; clears the box to empty, the pipe and the queue,
//   and loads the identity transform with transform disabled.
// ----------------------------------------------------------------------------
// bounding_box_accumulator: running 3-D axis-aligned bounding box
// Front end takes beats, drops unused modes and transforms points; a short
// queue decouples it from the back end, which widens or queries the box.
// ----------------------------------------------------------------------------
`default_nettype none

module bounding_box_accumulator
    import bba_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0]        i_cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]         i_cfg_data,
    // input channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [1:0]                        i_mode,
    input  wire logic                              i_first,
    input  wire logic                              i_last,
    input  wire logic signed [COORD_WIDTH-1:0]     i_ax,
    input  wire logic signed [COORD_WIDTH-1:0]     i_ay,
    input  wire logic signed [COORD_WIDTH-1:0]     i_az,
    input  wire logic signed [COORD_WIDTH-1:0]     i_bx,
    input  wire logic signed [COORD_WIDTH-1:0]     i_by,
    input  wire logic signed [COORD_WIDTH-1:0]     i_bz,
    // result channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic signed [COORD_WIDTH-1:0]          o_low_x,
    output logic signed [COORD_WIDTH-1:0]          o_low_y,
    output logic signed [COORD_WIDTH-1:0]          o_low_z,
    output logic signed [COORD_WIDTH-1:0]          o_high_x,
    output logic signed [COORD_WIDTH-1:0]          o_high_y,
    output logic signed [COORD_WIDTH-1:0]          o_high_z,
    output logic                                   o_overlap
);

    localparam int IW = CTL_WIDTH + 6 * COORD_WIDTH;
    localparam int LW = $clog2(QUEUE_DEPTH + 1);

    t_cfg          r_cfg;
    logic          q_push, q_pop, q_valid, q_full;
    logic [IW-1:0] q_push_data, q_data;
    logic [LW-1:0] q_level;
    logic [1:0]    f_inflight;
    logic          in_acc;

    // Writes are always taken; write only while the block is idle (not enforced)
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.xform_en <= 1'b0;
            r_cfg.row_x    <= ROW_X_RST;
            r_cfg.row_y    <= ROW_Y_RST;
            r_cfg.row_z    <= ROW_Z_RST;
            r_cfg.shift_x  <= '0;
            r_cfg.shift_y  <= '0;
            r_cfg.shift_z  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_XFORM_EN: r_cfg.xform_en <= i_cfg_data[0];
                CFG_ROW_X:    r_cfg.row_x    <= i_cfg_data[ROW_WIDTH-1:0];
                CFG_ROW_Y:    r_cfg.row_y    <= i_cfg_data[ROW_WIDTH-1:0];
                CFG_ROW_Z:    r_cfg.row_z    <= i_cfg_data[ROW_WIDTH-1:0];
                CFG_SHIFT_X:  r_cfg.shift_x  <= i_cfg_data[SHIFT_WIDTH-1:0];
                CFG_SHIFT_Y:  r_cfg.shift_y  <= i_cfg_data[SHIFT_WIDTH-1:0];
                CFG_SHIFT_Z:  r_cfg.shift_z  <= i_cfg_data[SHIFT_WIDTH-1:0];
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    // Front end: intake against queue credit, drop unused mode, transform points
    bba_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_first     (i_first),
        .i_last      (i_last),
        .i_ax        (i_ax),
        .i_ay        (i_ay),
        .i_az        (i_az),
        .i_bx        (i_bx),
        .i_by        (i_by),
        .i_bz        (i_bz),
        .i_cfg       (r_cfg),
        .i_q_level   (q_level),
        .o_push      (q_push),
        .o_push_data (q_push_data),
        .o_inflight  (f_inflight)
    );

    // Queue: lets the result side stall without stopping intake at once
    bba_fifo #(
        .WIDTH (IW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .i_pop       (q_pop),
        .o_valid     (q_valid),
        .o_data      (q_data),
        .o_level     (q_level),
        .o_full      (q_full)
    );

    // Back end: widen or query the stored box, hold the result beat
    bba_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_data),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_low_x     (o_low_x),
        .o_low_y     (o_low_y),
        .o_low_z     (o_low_z),
        .o_high_x    (o_high_x),
        .o_high_y    (o_high_y),
        .o_high_z    (o_high_z),
        .o_overlap   (o_overlap)
    );

    // The credit scheme must never push into a full queue
    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("item pushed into full queue");

    // Queued plus in-flight items never exceed the queue depth
    a_credit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((LW+1)'(q_level) + (LW+1)'(f_inflight)) <= (LW+1)'(QUEUE_DEPTH))
        else $error("queue credit exceeded");

    // An empty pipe with no intake cannot push next cycle
    a_no_phantom : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (f_inflight == 2'd0 && !in_acc) |=> !q_push)
        else $error("queue push without an accepted beat");

endmodule

`default_nettype wire

FILE: dv/tb_bounding_box_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounding_box_accumulator: self-checking bench for the 3-D box accumulator
// Drives point, merge and query beats under several transform settings with
// random gaps on the input and random stalls on the result channel, predicts
// every result box in a scoreboard and compares it field by field.
// ----------------------------------------------------------------------------

module tb_bounding_box_accumulator;
    import bba_pkg::*;

    localparam int CW = COORD_WIDTH_DEF;
    typedef logic signed [CW-1:0] t_coord;
    localparam t_coord C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam t_coord C_MIN = {1'b1, {(CW-1){1'b0}}};

    localparam int unsigned RANDOM_BEATS  = 600;
    localparam int unsigned PHASES        = 6;
    // comfortably longer than the pipe, covers beats that leave no result
    localparam int unsigned SETTLE_CYCLES = 12;

    // index 0 is x, 1 is y, 2 is z
    typedef struct packed {
        t_mode            mode;
        logic             first;
        logic             last;
        t_coord [2:0]     a;
        t_coord [2:0]     b;
    } t_beat;

    typedef struct packed {
        t_coord [2:0]     lo;
        t_coord [2:0]     hi;
        logic             overlap;
    } t_box_result;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the registers and the stored box, a queue of
    // boxes still owed by the block, and a count of failed comparisons.
    // ------------------------------------------------------------------------
    class box_scoreboard;
        logic                 xform_en;
        logic [ROW_WIDTH-1:0] row [3];
        t_coord               shift [3];
        longint               lo [3];
        longint               hi [3];
        t_box_result          boxes_due [$];
        int unsigned          errors;

        function new();
            xform_en = 1'b0;
            row[0]   = ROW_X_RST;
            row[1]   = ROW_Y_RST;
            row[2]   = ROW_Z_RST;
            foreach (shift[i]) shift[i] = '0;
            empty_box();
            errors = 0;
        endfunction

        function void empty_box();
            foreach (lo[i]) begin
                lo[i] = longint'(C_MAX);
                hi[i] = longint'(C_MIN);
            end
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_WIDTH-1:0] data);
            case (idx)
                CFG_XFORM_EN: xform_en = data[0];
                CFG_ROW_X:    row[0]   = data[ROW_WIDTH-1:0];
                CFG_ROW_Y:    row[1]   = data[ROW_WIDTH-1:0];
                CFG_ROW_Z:    row[2]   = data[ROW_WIDTH-1:0];
                CFG_SHIFT_X:  shift[0] = data[SHIFT_WIDTH-1:0];
                CFG_SHIFT_Y:  shift[1] = data[SHIFT_WIDTH-1:0];
                CFG_SHIFT_Z:  shift[2] = data[SHIFT_WIDTH-1:0];
                default: ;
            endcase
        endfunction

        // One output axis: Q2.14 dot product, round half up to an integer, add the
        // translation, clamp to the coordinate range.
        function longint transform_axis(int unsigned axis, longint p [3]);
            longint acc;
            longint q;
            acc = 0;
            for (int k = 0; k < 3; k++)
                acc += longint'($signed(row[axis][16*k +: 16])) * p[k];
            q = ((acc + 64'sd8192) >>> ROUND_SHIFT) + longint'(shift[axis]);
            if (q > longint'(C_MAX)) q = longint'(C_MAX);
            if (q < longint'(C_MIN)) q = longint'(C_MIN);
            return q;
        endfunction

        // Note one accepted beat; queue the box it makes the block emit.
        function void accept_beat(t_beat bt);
            longint      pa [3];
            longint      pb [3];
            longint      pt [3];
            logic        hit;
            t_box_result res;
            hit = 1'b0;
            for (int k = 0; k < 3; k++) begin
                pa[k] = longint'($signed(bt.a[k]));
                pb[k] = longint'($signed(bt.b[k]));
            end
            if (bt.mode == MODE_NONE) return;
            if (bt.mode == MODE_QUERY) begin
                // flags are ignored; the box, even an empty one, is used as stored
                hit = 1'b1;
                for (int k = 0; k < 3; k++)
                    if (!(lo[k] <= pb[k] && hi[k] >= pa[k])) hit = 1'b0;
            end else begin
                if (bt.first) empty_box();
                if (bt.mode == MODE_POINT) begin
                    for (int k = 0; k < 3; k++)
                        pt[k] = xform_en ? transform_axis(k, pa) : pa[k];
                    for (int k = 0; k < 3; k++) begin
                        if (pt[k] < lo[k]) lo[k] = pt[k];
                        if (pt[k] > hi[k]) hi[k] = pt[k];
                    end
                end else begin
                    // corners widen independently, inverted boxes included
                    for (int k = 0; k < 3; k++) begin
                        if (pa[k] < lo[k]) lo[k] = pa[k];
                        if (pb[k] > hi[k]) hi[k] = pb[k];
                    end
                end
                if (!bt.last) return;
            end
            for (int k = 0; k < 3; k++) begin
                res.lo[k] = t_coord'(lo[k]);
                res.hi[k] = t_coord'(hi[k]);
            end
            res.overlap = hit;
            boxes_due.push_back(res);
        endfunction

        function void compare_coord(string name, t_coord want, t_coord got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void match_result(t_box_result got);
            t_box_result want;
            string       axis [3];
            axis = '{"x", "y", "z"};
            if (boxes_due.size() == 0) begin
                errors++;
                $display("%0t: result beat with no box pending, actual lo %0d/%0d/%0d",
                         $time, got.lo[0], got.lo[1], got.lo[2]);
                return;
            end
            want = boxes_due.pop_front();
            for (int k = 0; k < 3; k++) begin
                compare_coord({"low_", axis[k]}, want.lo[k], got.lo[k]);
                compare_coord({"high_", axis[k]}, want.hi[k], got.hi[k]);
            end
            if (got.overlap !== want.overlap) begin
                errors++;
                $display("%0t: overlap mismatch, expected %0b, actual %0b",
                         $time, want.overlap, got.overlap);
            end
        endfunction

        function int unsigned pending();
            return boxes_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]   i_cfg_data  = '0;
    logic                        i_in_valid  = 1'b0;
    logic                        o_in_stall;
    logic [1:0]                  i_mode      = '0;
    logic                        i_first     = 1'b0;
    logic                        i_last      = 1'b0;
    t_coord                      i_ax = '0, i_ay = '0, i_az = '0;
    t_coord                      i_bx = '0, i_by = '0, i_bz = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    t_coord                      o_low_x, o_low_y, o_low_z;
    t_coord                      o_high_x, o_high_y, o_high_z;
    logic                        o_overlap;

    box_scoreboard sb = new();

    // no idling on either side in the closing stretch
    logic        tail_quiet   = 1'b0;
    int unsigned in_calm_left = 0;

    bounding_box_accumulator u_dut (.*);

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Result side: hold stall in random bursts with calm stretches in between;
    // check every beat taken at a rising edge.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : result_stall_gen
        int unsigned burst_left;
        int unsigned calm_left;
        if (tail_quiet) begin
            i_out_stall <= 1'b0;
        end else if (burst_left != 0) begin
            burst_left--;
            i_out_stall <= 1'b1;
        end else if (calm_left != 0) begin
            calm_left--;
            i_out_stall <= 1'b0;
        end else begin
            case ($urandom_range(0, 15))
                0: begin
                    calm_left = $urandom_range(20, 120);
                    i_out_stall <= 1'b0;
                end
                1, 2, 3, 4: begin
                    burst_left = $urandom_range(0, 7);
                    i_out_stall <= 1'b1;
                end
                default: i_out_stall <= 1'b0;
            endcase
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_box_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.lo      = {o_low_z, o_low_y, o_low_x};
            got.hi      = {o_high_z, o_high_y, o_high_x};
            got.overlap = o_overlap;
            sb.match_result(got);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_beat pack_beat(t_mode m, logic f, logic l,
                                        t_coord ax, t_coord ay, t_coord az,
                                        t_coord bx, t_coord by, t_coord bz);
        t_beat r;
        r.mode  = m;
        r.first = f;
        r.last  = l;
        r.a     = {az, ay, ax};
        r.b     = {bz, by, bx};
        return r;
    endfunction

    // mostly small values so boxes overlap, with extremes and full-range noise
    function automatic t_coord rand_coord();
        case ($urandom_range(0, 7))
            0:       return C_MAX;
            1:       return C_MIN;
            2, 3:    return t_coord'($urandom);
            default: return t_coord'($signed($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    function automatic logic [ROW_WIDTH-1:0] rand_row();
        logic [ROW_WIDTH-1:0] r;
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 5))
                0:       r[16*k +: 16] = 16'h4000;
                1:       r[16*k +: 16] = 16'h0000;
                2:       r[16*k +: 16] = 16'h7fff;
                3:       r[16*k +: 16] = 16'h8000;
                4:       r[16*k +: 16] = 16'($signed($urandom_range(0, 16'h2000)) - 16'sh1000);
                default: r[16*k +: 16] = 16'($urandom);
            endcase
        end
        return r;
    endfunction

    function automatic t_beat random_beat(t_mode m, logic f, logic l);
        t_beat  r;
        t_coord t;
        r = pack_beat(m, f, l, rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord());
        if (m == MODE_QUERY && $urandom_range(0, 1) == 0) begin
            // a modest, well-ordered query box near the origin
            for (int k = 0; k < 3; k++) begin
                r.a[k] = t_coord'($signed($urandom_range(0, 8192)) - 4096);
                r.b[k] = r.a[k] + t_coord'($urandom_range(0, 30000));
            end
        end else if (m == MODE_MERGE && $urandom_range(0, 3) != 0) begin
            // order most merge boxes; leave the rest possibly inverted
            for (int k = 0; k < 3; k++) begin
                if (r.a[k] > r.b[k]) begin
                    t      = r.a[k];
                    r.a[k] = r.b[k];
                    r.b[k] = t;
                end
            end
        end
        return r;
    endfunction

    // Present one beat from a falling edge, hold it until taken, note it.
    task automatic drive_beat(t_beat bt);
        int unsigned gap;
        gap = 0;
        if (!tail_quiet) begin
            if (in_calm_left != 0) begin
                in_calm_left--;
            end else begin
                case ($urandom_range(0, 15))
                    0:          in_calm_left = $urandom_range(20, 80);
                    1, 2, 3, 4: gap = $urandom_range(1, 8);
                    default: ;
                endcase
            end
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= bt.mode;
        i_first    <= bt.first;
        i_last     <= bt.last;
        i_ax       <= bt.a[0];
        i_ay       <= bt.a[1];
        i_az       <= bt.a[2];
        i_bx       <= bt.b[0];
        i_by       <= bt.b[1];
        i_bz       <= bt.b[2];
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.accept_beat(bt);
        @(negedge i_clk);
    endtask

    // Stop sending and wait until every owed box has come, then let the pipe
    // empty of beats that produce nothing.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_WIDTH-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Drain first: registers change only while the block is idle.
    task automatic set_transform(logic en, logic [ROW_WIDTH-1:0] rx,
                                 logic [ROW_WIDTH-1:0] ry, logic [ROW_WIDTH-1:0] rz,
                                 t_coord sx, t_coord sy, t_coord sz);
        drain();
        write_reg(CFG_XFORM_EN, CFG_DATA_WIDTH'(en));
        write_reg(CFG_ROW_X,    rx);
        write_reg(CFG_ROW_Y,    ry);
        write_reg(CFG_ROW_Z,    rz);
        write_reg(CFG_SHIFT_X,  {{(CFG_DATA_WIDTH-CW){1'b0}}, sx});
        write_reg(CFG_SHIFT_Y,  {{(CFG_DATA_WIDTH-CW){1'b0}}, sy});
        write_reg(CFG_SHIFT_Z,  {{(CFG_DATA_WIDTH-CW){1'b0}}, sz});
    endtask

    // Mostly well-formed first..last runs; the rest queries, noise (unused
    // mode included) and runs with stray flags.
    task automatic random_traffic(int unsigned count);
        int unsigned done;
        int unsigned n;
        t_mode       m;
        done = 0;
        while (done < count) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    n = $urandom_range(1, 6);
                    for (int j = 0; j < n; j++) begin
                        m = ($urandom_range(0, 2) == 0) ? MODE_MERGE : MODE_POINT;
                        drive_beat(random_beat(m, j == 0, j == n - 1));
                    end
                    done += n;
                end
                6, 7: begin
                    drive_beat(random_beat(MODE_QUERY, 1'($urandom), 1'($urandom)));
                    done++;
                end
                8: begin
                    m = t_mode'($urandom_range(0, 3));
                    drive_beat(random_beat(m, 1'($urandom), 1'($urandom)));
                    if (m != MODE_NONE) done++;
                end
                default: begin
                    n = $urandom_range(1, 4);
                    for (int j = 0; j < n; j++) begin
                        m = ($urandom_range(0, 1) == 0) ? MODE_MERGE : MODE_POINT;
                        drive_beat(random_beat(m, 1'($urandom), 1'($urandom)));
                    end
                    done += n;
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: transform off, box empty.
        // The empty box only meets a query spanning the whole range; the
        // flags on a query must be ignored.
        drive_beat(pack_beat(MODE_QUERY, 1'b1, 1'b0, C_MIN, C_MIN, C_MIN,
                             C_MAX, C_MAX, C_MAX));
        drive_beat(pack_beat(MODE_QUERY, 1'b0, 1'b1, -24'sd100, -24'sd100, -24'sd100,
                             24'sd100, 24'sd100, 24'sd100));
        // point run hitting both coordinate extremes
        drive_beat(pack_beat(MODE_POINT, 1'b1, 1'b0, C_MAX, C_MIN, '0, '0, '0, '0));
        drive_beat(pack_beat(MODE_POINT, 1'b0, 1'b1, C_MIN, C_MAX, -24'sd1,
                             '0, '0, '0));
        // inverted merge box: low and high corners widen on their own
        drive_beat(pack_beat(MODE_MERGE, 1'b1, 1'b1, 24'sd100, 24'sd200, 24'sd300,
                             -24'sd100, -24'sd200, -24'sd300));
        // unused mode: drop the beat, keep the box, no result
        drive_beat(pack_beat(MODE_NONE, 1'b1, 1'b1, C_MIN, C_MIN, C_MIN,
                             C_MAX, C_MAX, C_MAX));
        // query touching the stored box exactly on every boundary
        drive_beat(pack_beat(MODE_QUERY, 1'b1, 1'b1, -24'sd100, -24'sd200, -24'sd300,
                             24'sd100, 24'sd200, 24'sd300));
        drive_beat(pack_beat(MODE_QUERY, 1'b0, 1'b0, 24'sd101, -24'sd200, -24'sd300,
                             24'sd200, 24'sd200, 24'sd300));
        // merge run without a result until its last beat
        drive_beat(pack_beat(MODE_MERGE, 1'b0, 1'b0, C_MIN, C_MIN, C_MIN,
                             C_MAX, C_MAX, C_MAX));
        drive_beat(pack_beat(MODE_MERGE, 1'b0, 1'b1, '0, '0, '0, '0, '0, '0));
        drive_beat(pack_beat(MODE_POINT, 1'b1, 1'b1, 24'sh555555, 24'shaaaaaa,
                             24'sh555555, 24'shaaaaaa, 24'sh555555, 24'shaaaaaa));

        // Extreme matrix and shifts: x and y saturate both ways, z is x/2 to
        // exercise round half up on positive and negative halves.
        set_transform(1'b1, {3{16'h7fff}}, {3{16'h8000}}, {32'h0, 16'h2000},
                      C_MAX, C_MIN, '0);
        drive_beat(pack_beat(MODE_POINT, 1'b1, 1'b1, C_MAX, C_MAX, C_MAX, '0, '0, '0));
        drive_beat(pack_beat(MODE_POINT, 1'b1, 1'b1, C_MIN, C_MIN, C_MIN, '0, '0, '0));
        drive_beat(pack_beat(MODE_POINT, 1'b1, 1'b1, 24'sd1, '0, '0, '0, '0, '0));
        drive_beat(pack_beat(MODE_POINT, 1'b1, 1'b1, -24'sd1, '0, '0, '0, '0, '0));
        drive_beat(pack_beat(MODE_POINT, 1'b1, 1'b0, 24'sd3, '0, '0, '0, '0, '0));
        drive_beat(pack_beat(MODE_POINT, 1'b0, 1'b1, -24'sd3, '0, '0, '0, '0, '0));
        // merge ignores the transform
        drive_beat(pack_beat(MODE_MERGE, 1'b1, 1'b1, -24'sd5, -24'sd5, -24'sd5,
                             24'sd5, 24'sd5, 24'sd5));

        // Random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: set_transform(1'b0, rand_row(), rand_row(), rand_row(),
                                 rand_coord(), rand_coord(), rand_coord());
                1: set_transform(1'b1, ROW_X_RST, ROW_Y_RST, ROW_Z_RST,
                                 rand_coord(), rand_coord(), rand_coord());
                2: set_transform(1'b1, '1, '1, '1, C_MAX, C_MAX, C_MAX);
                3: set_transform(1'b1, '0, rand_row(), '1, C_MIN, rand_coord(), C_MIN);
                default: set_transform(1'($urandom), rand_row(), rand_row(), rand_row(),
                                       rand_coord(), rand_coord(), rand_coord());
            endcase
            if (p == PHASES - 1) tail_quiet = 1'b1;
            random_traffic(RANDOM_BEATS / PHASES);
        end

        drain();
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Hang guard: far beyond the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
